>>> src/opfb_pkg.sv
// Package for the page-layout frame store and refresh packer.
// Holds display geometry, stream constants, shared types and the window byte table.
// No dependencies.
`default_nettype none

package opfb_pkg;

  localparam int DISPLAY_WIDTH  = 128;
  localparam int DISPLAY_HEIGHT = 64;
  localparam int PAGES          = (DISPLAY_HEIGHT + 7) / 8;
  localparam int DATA_BYTES     = DISPLAY_WIDTH * PAGES;
  localparam int CMD_MSGS       = 6;
  localparam int CMD_BYTES      = 3 * CMD_MSGS;
  localparam int STORE_DEPTH    = 1024;
  localparam int ADDR_W         = $clog2(STORE_DEPTH);
  localparam int POS_W          = 11;
  localparam int LAST_POS       = CMD_BYTES + 1 + DATA_BYTES;

  localparam logic [7:0] CTRL_CMD      = 8'h00;
  localparam logic [7:0] CTRL_DATA     = 8'h40;
  localparam logic [7:0] CMD_COL_ADDR  = 8'h21;
  localparam logic [7:0] CMD_PAGE_ADDR = 8'h22;

  localparam logic CFG_ROTATE  = 1'b0;
  localparam logic CFG_BUS_ADR = 1'b1;

  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_FETCH = 2'd2
  } kind_t;

  typedef enum logic {
    ST_RUN   = 1'b0,
    ST_CLEAR = 1'b1
  } clr_state_t;

  typedef struct packed {
    logic [7:0]        stream_byte;
    logic              from_mem;
    logic [ADDR_W-1:0] mem_addr;
    logic              message_start;
    logic              message_end;
    logic              frame_end;
  } stream_info_t;

  function automatic logic [7:0] window_byte(input logic [2:0] msg);
    logic [7:0] b;
    case (msg)
      3'd0: b = CMD_COL_ADDR;
      3'd1: b = 8'h00;
      3'd2: b = 8'(DISPLAY_WIDTH - 1);
      3'd3: b = CMD_PAGE_ADDR;
      3'd4: b = 8'h00;
      default: b = 8'(PAGES - 1);
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

>>> src/opfb_intf.sv
// Valid/ready channel interfaces for the frame store block.
// One interface for request words, one for stream words; no dependencies.
`default_nettype none

interface opfb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] pixel_column;
  logic [6:0] pixel_row;
  logic       pixel_on;

  modport source (output valid, kind, pixel_column, pixel_row, pixel_on, input ready);
  modport sink   (input valid, kind, pixel_column, pixel_row, pixel_on, output ready);
endinterface

interface opfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic       message_start;
  logic       message_end;
  logic       frame_end;

  modport source (output valid, stream_byte, message_start, message_end, frame_end,
                  input ready);
  modport sink   (input valid, stream_byte, message_start, message_end, frame_end,
                  output ready);
endinterface

`default_nettype wire

>>> src/opfb_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module opfb_ram #(
  parameter int ADDR_W = 10,
  parameter int DATA_W = 8
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> src/opfb_stream.sv
// Refresh stream sequencer: holds the stream position and decodes the next word.
// Depends on opfb_pkg.
`default_nettype none

module opfb_stream
  import opfb_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         advance,
  input  wire logic [6:0]   bus_address,
  output stream_info_t      info
);

  logic [POS_W-1:0] pos, pos_next;
  logic [1:0]       cmd_off, cmd_off_next;
  logic [2:0]       cmd_msg, cmd_msg_next;

  logic [7:0]       addr_byte;
  logic             in_cmd;
  logic [POS_W-1:0] data_pos;

  assign addr_byte = {bus_address, 1'b0};
  assign in_cmd    = pos < POS_W'(CMD_BYTES);
  assign data_pos  = pos - POS_W'(CMD_BYTES);

  always_comb begin
    info = '0;
    info.mem_addr = ADDR_W'(pos - POS_W'(CMD_BYTES + 2));
    if (in_cmd) begin
      case (cmd_off)
        2'd0: begin
          info.stream_byte   = addr_byte;
          info.message_start = 1'b1;
        end
        2'd1: info.stream_byte = CTRL_CMD;
        default: begin
          info.stream_byte = window_byte(cmd_msg);
          info.message_end = 1'b1;
        end
      endcase
    end else if (data_pos == '0) begin
      info.stream_byte   = addr_byte;
      info.message_start = 1'b1;
    end else if (data_pos == POS_W'(1)) begin
      info.stream_byte = CTRL_DATA;
    end else begin
      info.from_mem    = 1'b1;
      info.frame_end   = pos >= POS_W'(LAST_POS);
      info.message_end = info.frame_end;
    end
  end

  always_comb begin
    pos_next     = pos;
    cmd_off_next = cmd_off;
    cmd_msg_next = cmd_msg;
    if (advance) begin
      if (info.frame_end) begin
        pos_next     = '0;
        cmd_off_next = '0;
        cmd_msg_next = '0;
      end else begin
        pos_next = pos + POS_W'(1);
        if (in_cmd) begin
          if (cmd_off == 2'd2) begin
            cmd_off_next = '0;
            cmd_msg_next = cmd_msg + 3'd1;
          end else begin
            cmd_off_next = cmd_off + 2'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      cmd_off <= '0;
      cmd_msg <= '0;
    end else begin
      pos     <= pos_next;
      cmd_off <= cmd_off_next;
      cmd_msg <= cmd_msg_next;
    end
  end

endmodule

`default_nettype wire

>>> src/oled_page_framebuffer_packer.sv
// Top level of the page-layout frame store and refresh stream packer.
// Depends on opfb_pkg, opfb_intf, opfb_ram and opfb_stream.
//
// The frame store is a 1024-byte synchronous RAM in page layout; pixel writes are
// read-modify-write through a two-stage pipeline with forwarding; pixel writes are
// taken one per cycle unless a fetch is in the second stage or the output stalls.
// A fetch's word passes the RAM read and then the single output register. After
// reset and every clear request the block sweeps the RAM, one byte per cycle, and
// takes no request word meanwhile; configuration writes are taken at any time.
`default_nettype none

module oled_page_framebuffer_packer
  import opfb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write_en,
  input  wire logic       cfg_index,
  input  wire logic [6:0] cfg_data,
  opfb_in_if.sink         in_ch,
  opfb_out_if.source      out_ch
);

  logic       rotate_180;
  logic [6:0] bus_address;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotate_180  <= 1'b0;
      bus_address <= 7'd60;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_ROTATE:  rotate_180  <= cfg_data[0];
        CFG_BUS_ADR: bus_address <= cfg_data;
        default: ;
      endcase
    end
  end

  clr_state_t        state, state_next;
  logic [ADDR_W-1:0] clr_cnt;
  logic              sweep_active;

  logic  accept;
  kind_t kind;
  assign accept = in_ch.valid && in_ch.ready;
  assign kind   = kind_t'(in_ch.kind);

  always_comb begin
    state_next = state;
    case (state)
      ST_RUN: begin
        if (accept && kind == KIND_CLEAR) begin
          state_next = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        if (clr_cnt == '1) begin
          state_next = ST_RUN;
        end
      end
      default: state_next = ST_RUN;
    endcase
  end

  always_comb begin
    case (state)
      ST_CLEAR: sweep_active = 1'b1;
      default:  sweep_active = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (sweep_active) begin
        clr_cnt <= clr_cnt + ADDR_W'(1);
      end else begin
        clr_cnt <= '0;
      end
    end
  end

  // Pixel address, with optional mirroring in both axes.
  logic [7:0]        col_eff;
  logic [6:0]        row_eff;
  logic              on_display;
  logic [ADDR_W-1:0] pix_addr;

  assign on_display = (in_ch.pixel_column < 8'(DISPLAY_WIDTH)) &&
                      (in_ch.pixel_row < 7'(DISPLAY_HEIGHT));
  assign col_eff = rotate_180 ? 8'(DISPLAY_WIDTH - 1) - in_ch.pixel_column
                              : in_ch.pixel_column;
  assign row_eff = rotate_180 ? 7'(DISPLAY_HEIGHT - 1) - in_ch.pixel_row
                              : in_ch.pixel_row;
  assign pix_addr = ADDR_W'(({6'd0, row_eff[6:3]} * ADDR_W'(DISPLAY_WIDTH)) +
                            {2'd0, col_eff});

  stream_info_t info;
  logic         fetch_go;
  assign fetch_go = accept && kind == KIND_FETCH;

  opfb_stream u_stream (
    .clk         (clk),
    .rst         (rst),
    .advance     (fetch_go),
    .bus_address (bus_address),
    .info        (info)
  );

  // Second stage: RAM data is back; modify and write, or hand the word out.
  logic              s1_write, s1_fetch;
  logic [ADDR_W-1:0] s1_addr;
  logic [2:0]        s1_bit;
  logic              s1_on;
  stream_info_t      s1_info;
  logic              fwd_hit;
  logic [7:0]        fwd_data;
  logic [7:0]        rd_data, cur_byte, new_byte;
  logic [ADDR_W-1:0] rd_addr;

  assign rd_addr  = (kind == KIND_PIXEL) ? pix_addr : info.mem_addr;
  assign cur_byte = fwd_hit ? fwd_data : rd_data;
  assign new_byte = s1_on ? (cur_byte | (8'd1 << s1_bit))
                          : (cur_byte & ~(8'd1 << s1_bit));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_write <= 1'b0;
      s1_fetch <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      s1_write <= accept && kind == KIND_PIXEL && on_display;
      s1_fetch <= fetch_go;
      fwd_hit  <= accept && s1_write && s1_addr == rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr  <= rd_addr;
      s1_bit   <= row_eff[2:0];
      s1_on    <= in_ch.pixel_on;
      s1_info  <= info;
      fwd_data <= new_byte;
    end
  end

  opfb_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (8)
  ) u_ram (
    .clk   (clk),
    .we    (sweep_active || s1_write),
    .waddr (sweep_active ? clr_cnt : s1_addr),
    .wdata (sweep_active ? 8'd0 : new_byte),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (s1_fetch) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fetch) begin
      out_ch.stream_byte   <= s1_info.from_mem ? cur_byte : s1_info.stream_byte;
      out_ch.message_start <= s1_info.message_start;
      out_ch.message_end   <= s1_info.message_end;
      out_ch.frame_end     <= s1_info.frame_end;
    end
  end

  assign in_ch.ready = !sweep_active && !s1_fetch && !(out_ch.valid && !out_ch.ready);

endmodule

`default_nettype wire

>>> src/opfb_checker.sv
// Port-level checks on the stream channel of the frame store block, and their binding.
// Depends on oled_page_framebuffer_packer and opfb_out_if.
`default_nettype none

module opfb_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [7:0] out_byte,
  input wire logic out_start,
  input wire logic out_mend,
  input wire logic out_fend
);

  a_fend_ends_message: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_fend |-> out_mend)
    else $error("Frame end word does not close its message.");

  a_start_not_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_start |-> !out_mend)
    else $error("A message opened and closed on the same word.");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("Stream word dropped while stalled.");

  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_byte) && $stable(out_fend))
    else $error("Stream word changed while stalled.");

endmodule

bind oled_page_framebuffer_packer opfb_checker u_opfb_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.stream_byte),
  .out_start (out_ch.message_start),
  .out_mend  (out_ch.message_end),
  .out_fend  (out_ch.frame_end)
);

`default_nettype wire
